// ----- hw/rtl/ilie_pkg.sv -----
// Shared types and command codes for the indexed list insert/erase engine.
package ilie_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
    } t_rsp;

    // Operation broadcast to every cell of the chain in the cycle a request is taken.
    typedef struct packed {
        logic                     insert;
        logic                     erase;
        logic [POS_W-2:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_op;

endpackage

// ----- hw/rtl/ilie_req_if.sv -----
// Request channel interface: valid, ready and the request payload.
interface ilie_req_if;
    logic              valid;
    logic              ready;
    ilie_pkg::t_req    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/ilie_rsp_if.sv -----
// Response channel interface: valid, ready and the response payload.
interface ilie_rsp_if;
    logic              valid;
    logic              ready;
    ilie_pkg::t_rsp    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/ilie_cell.sv -----
// One list slot: holds, shifts up, shifts down or loads its entry each cycle.
module ilie_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  ilie_pkg::t_cell_op                i_op,
    input  logic signed [ilie_pkg::DATA_W-1:0] i_lower,
    input  logic signed [ilie_pkg::DATA_W-1:0] i_upper,
    output logic signed [ilie_pkg::DATA_W-1:0] o_data,
    output logic                              o_hit
);
    import ilie_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    int                       pos_i;

    always_comb begin
        pos_i = int'(i_op.pos);
        n_data = r_data;
        if (i_op.insert) begin
            if (IDX > pos_i) begin
                n_data = i_lower;
            end else if (IDX == pos_i) begin
                n_data = i_op.value;
            end
        end else if (i_op.erase) begin
            if (IDX >= pos_i) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (int'(i_op.pos) == IDX);

endmodule

// ----- hw/rtl/indexed_list_insert_erase.sv -----
// Top level of the indexed list engine: request decode, cell chain and response register.
//
// Requests arrive on i_req with a command (insert, erase or read), a signed
// position and a value. Each request gives exactly one response on o_rsp with
// an ok flag, the read value (zero unless a read succeeds) and the new length.
// The list is a chain of CAPACITY cells; on an insert the cells above the
// position each take their lower neighbor's entry, on an erase the cells at
// and above it take their upper neighbor's entry, all in the same cycle.
// A request is decoded and applied in the cycle it is taken, and its response
// appears in the output register in the following cycle; one request can be taken
// every cycle unless a held response stalls the input. The read path is a select over the
// cell outputs, which sets the cycle time together with the position compare.
// A response waiting in the output register is held while o_rsp.ready is low;
// a new request is taken only when that register is empty or being emptied.
// Reset empties the list (length zero) and marks the output register empty;
// entry contents are not reset since no slot at or above the length is ever read.
module indexed_list_insert_erase #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilie_req_if.sink   i_req,
    ilie_rsp_if.source o_rsp
);
    import ilie_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    logic               accept;
    logic               neg;
    logic [CMPW-1:0]    pos_x;
    logic [CMPW-1:0]    cnt_x;
    logic               full;
    logic               ins_ok;
    logic               idx_ok;
    t_cell_op           cell_op;
    logic signed [DATA_W-1:0] rd_data;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic                     cell_hit  [CAPACITY];

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign neg    = i_req.payload.position[POS_W-1];
    assign pos_x  = CMPW'(i_req.payload.position[POS_W-2:0]);
    assign cnt_x  = CMPW'(r_count);
    assign full   = (r_count == CW'(CAPACITY));
    assign ins_ok = !neg && !full && (pos_x <= cnt_x);
    assign idx_ok = !neg && (pos_x < cnt_x);

    always_comb begin
        cell_op.insert = accept && (i_req.payload.command == CMD_INSERT) && ins_ok;
        cell_op.erase  = accept && (i_req.payload.command == CMD_ERASE) && idx_ok;
        cell_op.pos    = i_req.payload.position[POS_W-2:0];
        cell_op.value  = i_req.payload.value;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;

        if (g == 0) begin : g_first
            assign lower = i_req.payload.value;
        end else begin : g_mid_lo
            assign lower = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign upper = cell_data[g];
        end else begin : g_mid_hi
            assign upper = cell_data[g+1];
        end

        ilie_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (cell_data[g]),
            .o_hit   (cell_hit[g])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | (cell_data[k] & {DATA_W{cell_hit[k]}});
        end
    end

    always_comb begin
        n_count        = r_count;
        n_rsp.ok         = 1'b0;
        n_rsp.read_value = '0;
        case (i_req.payload.command)
            CMD_INSERT: begin
                if (ins_ok) begin
                    n_rsp.ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_ERASE: begin
                if (idx_ok) begin
                    n_rsp.ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    n_rsp.ok         = 1'b1;
                    n_rsp.read_value = rd_data;
                end
            end
            default: begin
                n_rsp.ok = 1'b0;
            end
        endcase
        n_rsp.length = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.payload = r_rsp;

endmodule

// ----- dv/ilie_list_checker.sv -----
// Watches both channels of the indexed list engine, predicts each response and compares it.
module ilie_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ilie_req_if  i_req,
    ilie_rsp_if  i_rsp,
    output int   o_error_count,
    output int   o_pending,
    output int   o_list_length
);
    import ilie_pkg::*;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;
    t_rsp                     pending_list_rsps [$];
    int                       mismatches = 0;
    int                       outstanding = 0;

    assign o_error_count = mismatches;
    assign o_pending     = outstanding;
    assign o_list_length = list_len;

    function automatic t_rsp apply_list_op(input t_req r);
        t_rsp res;
        int   p;
        int   i;
        res = '0;
        p   = int'(r.position[POS_W-2:0]);
        if (!r.position[POS_W-1]) begin
            case (r.command)
                CMD_INSERT: begin
                    if (p <= list_len && list_len < CAPACITY) begin
                        for (i = list_len; i > p; i--) begin
                            list_mem[i] = list_mem[i-1];
                        end
                        list_mem[p] = r.value;
                        list_len++;
                        res.ok = 1'b1;
                    end
                end
                CMD_ERASE: begin
                    if (p < list_len) begin
                        for (i = p; i + 1 < list_len; i++) begin
                            list_mem[i] = list_mem[i+1];
                        end
                        list_len--;
                        res.ok = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (p < list_len) begin
                        res.ok         = 1'b1;
                        res.read_value = list_mem[p];
                    end
                end
                default: ;
            endcase
        end
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            list_len = 0;
            pending_list_rsps.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (pending_list_rsps.size() == 0) begin
                    $error("Unexpected response: ok=%0d read_value=%0d length=%0d",
                           got.ok, got.read_value, got.length);
                    mismatches++;
                end else begin
                    want = pending_list_rsps.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("Field ok: expected %0d, got %0d", want.ok, got.ok);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("Field read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.length !== want.length) begin
                        $error("Field length: expected %0d, got %0d",
                               want.length, got.length);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_list_rsps.push_back(apply_list_op(i_req.payload));
            end
        end
        outstanding = pending_list_rsps.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the indexed list engine: clock, reset, request stimulus and verdict.
module tb_top;
    import ilie_pkg::*;

    localparam int          CAPACITY    = 64;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          PHASE_ITEMS = 275;
    localparam int          HOLD_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilie_req_if req_ch ();
    ilie_rsp_if rsp_ch ();

    int error_count;
    int pending;
    int list_length;

    int send_idle_pct = 7;
    int recv_idle_pct = 82;
    int rsp_taken     = 0;
    int long_holds    = 0;
    int n_insert      = 0;
    int n_erase       = 0;
    int n_read        = 0;
    int n_unused      = 0;
    int full_inserts  = 0;

    always #5 i_clk = ~i_clk;

    indexed_list_insert_erase #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ilie_list_checker #(
        .CAPACITY (CAPACITY)
    ) list_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_list_length (list_length)
    );

    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken <= rsp_taken + 1;
        end
    end

    // The response side occasionally holds off for a long stretch so the engine backs up.
    initial begin : response_side
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready = 1'b0;
            end else if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else if (long_holds < 2 && rsp_taken >= (long_holds + 1) * 250) begin
                rsp_ch.ready = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                long_holds++;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic drive_request(input logic [1:0] cmd, input logic signed [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid            = 1'b1;
        req_ch.payload.command  = cmd;
        req_ch.payload.position = pos;
        req_ch.payload.value    = val;
        case (cmd)
            CMD_INSERT: n_insert++;
            CMD_ERASE:  n_erase++;
            CMD_READ:   n_read++;
            default:    n_unused++;
        endcase
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_op(input int insert_wt, input int erase_wt);
        logic [1:0]               cmd;
        logic signed [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] val;
        int                       len;
        int                       top_pos;
        int                       pick;
        len = list_length;
        pick = $urandom_range(99);
        if (pick < 4) begin
            val = (pick < 1) ? 32'sh8000_0000 : (pick < 2) ? 32'sh7FFF_FFFF :
                  (pick < 3) ? 32'sh0 : -32'sd1;
        end else begin
            val = $urandom;
        end
        if ($urandom_range(99) < 8) begin
            cmd = 2'($urandom_range(3));
            pos = POS_W'($urandom_range(255));
        end else begin
            pick = $urandom_range(99);
            if (pick < insert_wt) begin
                cmd = CMD_INSERT;
            end else if (pick < insert_wt + erase_wt) begin
                cmd = CMD_ERASE;
            end else begin
                cmd = CMD_READ;
            end
            top_pos = (cmd == CMD_INSERT) ? len : ((len == 0) ? 0 : len - 1);
            pick    = $urandom_range(99);
            if (pick < 20) begin
                pos = '0;
            end else if (pick < 40) begin
                pos = POS_W'(top_pos);
            end else begin
                pos = POS_W'($urandom_range(top_pos));
            end
        end
        if (cmd == CMD_INSERT && len == CAPACITY) begin
            full_inserts++;
        end
        drive_request(cmd, pos, val);
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int ph;
        int k;
        i_rst_n                 = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.payload.command  = CMD_INSERT;
        req_ch.payload.position = '0;
        req_ch.payload.value    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        drive_request(CMD_READ,   8'sd0,   $urandom);
        drive_request(CMD_ERASE,  8'sd0,   $urandom);
        drive_request(CMD_INSERT, 8'sd1,   $urandom);
        drive_request(CMD_INSERT, -8'sd1,  $urandom);
        drive_request(CMD_INSERT, 8'sh80,  $urandom);
        drive_request(CMD_INSERT, 8'sd0,   32'sh7FFF_FFFF);
        drive_request(CMD_INSERT, 8'sd0,   32'sh8000_0000);
        drive_request(CMD_INSERT, 8'sd2,   32'sh0);
        drive_request(CMD_INSERT, 8'sd1,   -32'sd1);
        drive_request(CMD_READ,   8'sd0,   $urandom);
        drive_request(CMD_READ,   8'sd1,   $urandom);
        drive_request(CMD_READ,   8'sd2,   $urandom);
        drive_request(CMD_READ,   8'sd3,   $urandom);
        drive_request(CMD_READ,   8'sd4,   $urandom);
        drive_request(CMD_ERASE,  8'sd4,   $urandom);
        drive_request(CMD_INSERT, 8'sd5,   $urandom);
        drive_request(CMD_INSERT, 8'sd127, $urandom);
        drive_request(CMD_READ,   -8'sd1,  $urandom);
        drive_request(CMD_ERASE,  8'sh80,  $urandom);
        drive_request(CMD_UNUSED, 8'sd0,   $urandom);
        drive_request(CMD_UNUSED, -8'sd1,  $urandom);
        drive_request(CMD_ERASE,  8'sd1,   $urandom);
        drive_request(CMD_ERASE,  8'sd2,   $urandom);
        drive_request(CMD_ERASE,  8'sd0,   $urandom);
        drive_request(CMD_READ,   8'sd0,   $urandom);
        req_ch.valid = 1'b0;
        wait_for_drain();

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 7 : 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k < 150) begin
                    send_random_op(70, 15);
                end else begin
                    send_random_op(15, 70);
                end
            end
            req_ch.valid = 1'b0;
            wait_for_drain();
        end

        repeat (8) @(negedge i_clk);
        $display("Sent %0d requests: %0d insert, %0d erase, %0d read, %0d unused code.",
                 n_insert + n_erase + n_read + n_unused, n_insert, n_erase, n_read,
                 n_unused);
        $display("Inserts tried on a full list: %0d; long response hold-offs: %0d.",
                 full_inserts, long_holds);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
